// ===== sv/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants for the ray/sphere intersection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

  // width of one multiplier slice; wide products are built from these
  localparam int MUL_CHUNK = 32;
  // register stages through rsi_mul
  localparam int MUL_LAT = 5;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== sv/rsi_mul.sv =====
// ----------------------------------------------------------------------------
// rsi_mul
// Pipelined signed multiplier built from MUL_CHUNK x MUL_CHUNK slices:
// magnitude, partial products, row sums, total, sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int CW = rsi_pkg::MUL_CHUNK;
  localparam int NA = (AW + CW - 1) / CW;
  localparam int NB = (BW + CW - 1) / CW;
  localparam int PW = AW + BW;

  logic [NA*CW-1:0] ma;
  logic [NB*CW-1:0] mb;
  logic             sgn0, sgn1, sgn2, sgn3;
  logic [2*CW-1:0]  pp [NA][NB];
  logic [PW-1:0]    row [NA];
  logic [PW-1:0]    row_next [NA];
  logic [PW-1:0]    tot;
  logic [PW-1:0]    tot_next;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (j * CW));
      end
    end
  end

  always_comb begin
    tot_next = '0;
    for (int i = 0; i < NA; i++) begin
      tot_next = tot_next + (row[i] << (i * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= (NA*CW)'($unsigned(a[AW-1] ? -a : a));
      mb   <= (NB*CW)'($unsigned(b[BW-1] ? -b : b));
      sgn0 <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ma[i*CW +: CW] * mb[j*CW +: CW];
        end
      end
      sgn1 <= sgn0;
      row  <= row_next;
      sgn2 <= sgn1;
      tot  <= tot_next;
      sgn3 <= sgn2;
      p    <= sgn3 ? -$signed(tot) : $signed(tot);
    end
  end

endmodule

`default_nettype wire

// ===== sv/rsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one root bit per stage (restoring).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt #(
  parameter int NW = 136,
  parameter int TW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   radicand,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_valid,
  output logic [NW/2-1:0]      root,
  output logic [TW-1:0]        out_tag
);

  localparam int SW = NW / 2;
  localparam int RW = SW + 2;

  logic          vld [SW];
  logic [TW-1:0] tag [SW];
  logic [RW-1:0] rem [SW];
  logic [SW-1:0] rt  [SW];
  logic [NW-1:0] rad [SW];

  genvar k;
  for (k = 0; k < SW; k++) begin : g_st
    logic          vld_i;
    logic [TW-1:0] tag_i;
    logic [RW-1:0] rem_i;
    logic [SW-1:0] rt_i;
    logic [NW-1:0] rad_i;
    logic [RW-1:0] rem2;
    logic [RW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_in
      assign vld_i = in_valid;
      assign tag_i = in_tag;
      assign rem_i = '0;
      assign rt_i  = '0;
      assign rad_i = radicand;
    end else begin : g_mid
      assign vld_i = vld[k-1];
      assign tag_i = tag[k-1];
      assign rem_i = rem[k-1];
      assign rt_i  = rt[k-1];
      assign rad_i = rad[k-1];
    end

    // bring down the next bit pair, try root*4+1
    assign rem2  = {rem_i[RW-3:0], rad_i[NW-1 -: 2]};
    assign trial = {rt_i, 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k] <= tag_i;
        rem[k] <= ge ? rem2 - trial : rem2;
        rt[k]  <= {rt_i[SW-2:0], ge};
        rad[k] <= rad_i << 2;
      end
    end
  end

  assign out_valid = vld[SW-1];
  assign root      = rt[SW-1];
  assign out_tag   = tag[SW-1];

endmodule

`default_nettype wire

// ===== sv/rsi_div.sv =====
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Dividend >> QW must be below the divisor for a true quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_div #(
  parameter int NW = 104,
  parameter int DW = 65,
  parameter int QW = 33,
  parameter int TW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   dividend,
  input  wire logic [DW-1:0]   divisor,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_valid,
  output logic [QW-1:0]        quotient,
  output logic                 rem_nz,
  output logic [TW-1:0]        out_tag
);

  logic          vld [QW];
  logic [TW-1:0] tag [QW];
  logic [DW-1:0] rem [QW];
  logic [QW-1:0] lo  [QW];
  logic [QW-1:0] q   [QW];
  logic [DW-1:0] dv  [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_st
    logic          vld_i;
    logic [TW-1:0] tag_i;
    logic [DW-1:0] rem_i;
    logic [QW-1:0] lo_i;
    logic [QW-1:0] q_i;
    logic [DW-1:0] dv_i;
    logic [DW:0]   r2;
    logic          ge;

    if (k == 0) begin : g_in
      assign vld_i = in_valid;
      assign tag_i = in_tag;
      assign rem_i = DW'(dividend >> QW);
      assign lo_i  = dividend[QW-1:0];
      assign q_i   = '0;
      assign dv_i  = divisor;
    end else begin : g_mid
      assign vld_i = vld[k-1];
      assign tag_i = tag[k-1];
      assign rem_i = rem[k-1];
      assign lo_i  = lo[k-1];
      assign q_i   = q[k-1];
      assign dv_i  = dv[k-1];
    end

    assign r2 = {rem_i, lo_i[QW-1]};
    assign ge = (r2 >= {1'b0, dv_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k] <= tag_i;
        rem[k] <= DW'(ge ? r2 - {1'b0, dv_i} : r2);
        lo[k]  <= lo_i << 1;
        q[k]   <= {q_i[QW-2:0], ge};
        dv[k]  <= dv_i;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quotient  = q[QW-1];
  assign rem_nz    = |rem[QW-1];
  assign out_tag   = tag[QW-1];

endmodule

`default_nettype wire

// ===== sv/rsi_obuf.sv =====
// ----------------------------------------------------------------------------
// rsi_obuf
// Two-entry result buffer; decouples the pipeline from output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_obuf #(
  parameter int DW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [DW-1:0]      out_data
);

  logic [DW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ray_sphere_intersect_top.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// Ray against one configured sphere, fixed point, fully pipelined.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    origin_*, dir_*, nearest_t
//   out       out_valid / out_ready  hit, hit_t
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One ray per cycle unless the output buffer is full; the square root and
// divider work one bit per stage.
// rst is synchronous; it clears valid bits and loads the register defaults.
// Stalls freeze the whole pipeline only when the two-entry output buffer is
// full, so results keep draining and input keeps flowing while one waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersect_top #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] origin_x,
  input  wire logic signed [COORD_WIDTH-1:0] origin_y,
  input  wire logic signed [COORD_WIDTH-1:0] origin_z,
  input  wire logic signed [COORD_WIDTH-1:0] dir_x,
  input  wire logic signed [COORD_WIDTH-1:0] dir_y,
  input  wire logic signed [COORD_WIDTH-1:0] dir_z,
  input  wire logic signed [COORD_WIDTH-1:0] nearest_t,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic signed [COORD_WIDTH-1:0]      hit_t
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int L    = rsi_pkg::MUL_LAT;
  localparam int VW   = W + 1;
  localparam int BW   = 2 * W + 3;
  localparam int DDW  = 2 * W + 2;
  localparam int VVW  = 2 * W + 4;
  localparam int EW   = 2 * W + 5;
  localparam int NTW  = W + DDW;
  localparam int DSW  = 4 * W + 8;
  localparam int SW   = DSW / 2;
  localparam int FW   = 2 * W + 7;
  localparam int LW   = FW + F;
  localparam int CMW  = ((LW > NTW) ? LW : NTW) + 1;
  localparam int QW   = W + 1;
  localparam int DVW  = DDW - 1;
  localparam int OVW  = (LW > DVW + QW) ? LW : DVW + QW;
  localparam logic [63:0] EPS_RAW = ((64'd1 << (2 * F)) + 64'd50000) / 64'd100000;
  localparam logic signed [FW-1:0] EPS_F = FW'(EPS_RAW);
  localparam logic [QW:0] LIM = (QW+1)'(1) << (W - 1);

  typedef struct packed {
    logic signed [BW-1:0]  b;
    logic signed [DDW-1:0] dd;
    logic signed [W-1:0]   nt;
  } mul2_side_t;

  typedef struct packed {
    logic                  pos;
    logic signed [BW-1:0]  b;
    logic signed [DDW-1:0] dd;
    logic signed [NTW-1:0] ntdd;
    logic signed [W-1:0]   nt;
  } sq_tag_t;

  typedef struct packed {
    logic                hit;
    logic                neg;
    logic                ovf;
    logic signed [W-1:0] nt;
  } dv_tag_t;

  // configuration
  logic signed [W-1:0] center_x, center_y, center_z;
  logic [W-2:0]        radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= (W-1)'(1) << F;
    end else if (cfg_valid) begin
      case (rsi_pkg::cfg_reg_t'(cfg_index))
        rsi_pkg::REG_CENTER_X: center_x <= cfg_data;
        rsi_pkg::REG_CENTER_Y: center_y <= cfg_data;
        rsi_pkg::REG_CENTER_Z: center_z <= cfg_data;
        rsi_pkg::REG_RADIUS:   radius   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic full;

  assign en       = ~full;
  assign in_ready = en;

  // stage 1: v = origin - center
  logic signed [VW-1:0] v1 [3];
  logic signed [W-1:0]  d1 [3];
  logic signed [W-1:0]  rr1;
  logic signed [W-1:0]  nt1;
  logic                 vld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1[0] <= VW'(origin_x) - VW'(center_x);
      v1[1] <= VW'(origin_y) - VW'(center_y);
      v1[2] <= VW'(origin_z) - VW'(center_z);
      d1[0] <= dir_x;
      d1[1] <= dir_y;
      d1[2] <= dir_z;
      rr1   <= $signed({1'b0, radius});
      nt1   <= nearest_t;
    end
  end

  // dot products and radius squared
  logic signed [VW+W-1:0] pvd [3];
  logic signed [2*W-1:0]  pdd [3];
  logic signed [2*VW-1:0] pvv [3];
  logic signed [2*W-1:0]  prr;

  genvar gi;
  for (gi = 0; gi < 3; gi++) begin : g_dot
    rsi_mul #(.AW(VW), .BW(W)) u_vd (
      .clk(clk), .en(en), .a(v1[gi]), .b(d1[gi]), .p(pvd[gi])
    );
    rsi_mul #(.AW(W), .BW(W)) u_dd (
      .clk(clk), .en(en), .a(d1[gi]), .b(d1[gi]), .p(pdd[gi])
    );
    rsi_mul #(.AW(VW), .BW(VW)) u_vv (
      .clk(clk), .en(en), .a(v1[gi]), .b(v1[gi]), .p(pvv[gi])
    );
  end

  rsi_mul #(.AW(W), .BW(W)) u_rr (
    .clk(clk), .en(en), .a(rr1), .b(rr1), .p(prr)
  );

  logic                dl1_vld [L];
  logic signed [W-1:0] dl1_nt  [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) dl1_vld[k] <= 1'b0;
    end else if (en) begin
      dl1_vld[0] <= vld1;
      for (int k = 1; k < L; k++) dl1_vld[k] <= dl1_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl1_nt[0] <= nt1;
      for (int k = 1; k < L; k++) dl1_nt[k] <= dl1_nt[k-1];
    end
  end

  // stage 2: sums
  logic signed [BW-1:0]  b_s2;
  logic signed [DDW-1:0] dd_s2;
  logic signed [VVW-1:0] vv_s2;
  logic signed [2*W-1:0] rr_s2;
  logic signed [W-1:0]   nt_s2;
  logic                  vld_s2;

  // stage 3: e = v.v - r^2
  logic signed [BW-1:0]  b_s3;
  logic signed [DDW-1:0] dd_s3;
  logic signed [EW-1:0]  e_s3;
  logic signed [W-1:0]   nt_s3;
  logic                  vld_s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s2 <= 1'b0;
      vld_s3 <= 1'b0;
    end else if (en) begin
      vld_s2 <= dl1_vld[L-1];
      vld_s3 <= vld_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s2  <= BW'(pvd[0]) + BW'(pvd[1]) + BW'(pvd[2]);
      dd_s2 <= DDW'(pdd[0]) + DDW'(pdd[1]) + DDW'(pdd[2]);
      vv_s2 <= VVW'(pvv[0]) + VVW'(pvv[1]) + VVW'(pvv[2]);
      rr_s2 <= prr;
      nt_s2 <= dl1_nt[L-1];
      b_s3  <= b_s2;
      dd_s3 <= dd_s2;
      e_s3  <= EW'(vv_s2) - EW'(rr_s2);
      nt_s3 <= nt_s2;
    end
  end

  // b^2, dd*e and nearest_t*dd
  logic signed [2*BW-1:0]   bb;
  logic signed [DDW+EW-1:0] ac;
  logic signed [NTW-1:0]    ntdd;

  rsi_mul #(.AW(BW), .BW(BW)) u_bb (
    .clk(clk), .en(en), .a(b_s3), .b(b_s3), .p(bb)
  );
  rsi_mul #(.AW(DDW), .BW(EW)) u_ac (
    .clk(clk), .en(en), .a(dd_s3), .b(e_s3), .p(ac)
  );
  rsi_mul #(.AW(W), .BW(DDW)) u_nd (
    .clk(clk), .en(en), .a(nt_s3), .b(dd_s3), .p(ntdd)
  );

  logic       dl2_vld  [L];
  mul2_side_t dl2_side [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) dl2_vld[k] <= 1'b0;
    end else if (en) begin
      dl2_vld[0] <= vld_s3;
      for (int k = 1; k < L; k++) dl2_vld[k] <= dl2_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl2_side[0] <= '{b: b_s3, dd: dd_s3, nt: nt_s3};
      for (int k = 1; k < L; k++) dl2_side[k] <= dl2_side[k-1];
    end
  end

  // stage 4: discriminant
  logic signed [DSW-1:0] disc_s4;
  sq_tag_t               sq_tag_s4;
  logic                  vld_s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s4 <= 1'b0;
    end else if (en) begin
      vld_s4 <= dl2_vld[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_s4        <= DSW'(bb) - DSW'(ac);
      sq_tag_s4.pos  <= (bb > ac);
      sq_tag_s4.b    <= dl2_side[L-1].b;
      sq_tag_s4.dd   <= dl2_side[L-1].dd;
      sq_tag_s4.ntdd <= ntdd;
      sq_tag_s4.nt   <= dl2_side[L-1].nt;
    end
  end

  logic          sq_vld;
  logic [SW-1:0] sq_root;
  sq_tag_t       sq_otag;

  rsi_sqrt #(.NW(DSW), .TW($bits(sq_tag_t))) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vld_s4), .radicand($unsigned(disc_s4)), .in_tag(sq_tag_s4),
    .out_valid(sq_vld), .root(sq_root), .out_tag(sq_otag)
  );

  // stage 5: far-root test and near root
  logic signed [FW-1:0]  s_ext;
  logic signed [FW-1:0]  far;
  logic signed [FW-1:0]  t1_s5;
  logic                  ok5;
  logic signed [DDW-1:0] dd_s5;
  logic signed [NTW-1:0] ntdd_s5;
  logic signed [W-1:0]   nt_s5;
  logic                  vld_s5;

  assign s_ext = FW'($signed({1'b0, sq_root}));
  assign far   = s_ext - FW'(sq_otag.b) + EPS_F;

  // stage 6: t1 * 2^F against nearest_t * dd
  logic signed [LW-1:0] lhs;
  logic                 lt;
  logic [LW-1:0]        mag_s6;
  logic                 hit_s6;
  logic                 neg_s6;
  logic [DVW-1:0]       dv_s6;
  logic signed [W-1:0]  nt_s6;
  logic                 vld_s6;

  assign lhs = LW'(t1_s5) <<< F;
  assign lt  = (CMW'(lhs) < CMW'(ntdd_s5));

  // stage 7: quotient range check
  logic [LW-1:0]  mag_s7;
  logic [DVW-1:0] dv_s7;
  dv_tag_t        dv_tag_s7;
  logic           vld_s7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s5 <= 1'b0;
      vld_s6 <= 1'b0;
      vld_s7 <= 1'b0;
    end else if (en) begin
      vld_s5 <= sq_vld;
      vld_s6 <= vld_s5;
      vld_s7 <= vld_s6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5     <= sq_otag.pos && (far > 0);
      t1_s5   <= -FW'(sq_otag.b) - s_ext;
      dd_s5   <= sq_otag.dd;
      ntdd_s5 <= sq_otag.ntdd;
      nt_s5   <= sq_otag.nt;

      mag_s6  <= lhs[LW-1] ? $unsigned(-lhs) : $unsigned(lhs);
      neg_s6  <= lhs[LW-1];
      hit_s6  <= ok5 && lt;
      dv_s6   <= dd_s5[DVW-1:0];
      nt_s6   <= nt_s5;

      mag_s7        <= mag_s6;
      dv_s7         <= dv_s6;
      dv_tag_s7.hit <= hit_s6;
      dv_tag_s7.neg <= neg_s6;
      dv_tag_s7.ovf <= (OVW'(mag_s6) >= (OVW'(dv_s6) << QW));
      dv_tag_s7.nt  <= nt_s6;
    end
  end

  logic          dq_vld;
  logic [QW-1:0] dq;
  logic          dq_rnz;
  dv_tag_t       dq_tag;

  rsi_div #(.NW(LW), .DW(DVW), .QW(QW), .TW($bits(dv_tag_t))) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vld_s7), .dividend(mag_s7), .divisor(dv_s7), .in_tag(dv_tag_s7),
    .out_valid(dq_vld), .quotient(dq), .rem_nz(dq_rnz), .out_tag(dq_tag)
  );

  // stage 8: floor, saturate, select
  logic [QW:0]  qn;
  logic [QW:0]  qn_neg;
  logic         sat;
  logic [W-1:0] val;

  always_comb begin
    qn     = {1'b0, dq} + {{QW{1'b0}}, dq_rnz};
    qn_neg = -qn;
    if (dq_tag.ovf) begin
      sat = 1'b1;
    end else if (dq_tag.neg) begin
      sat = (qn > LIM);
    end else begin
      sat = ({1'b0, dq} >= LIM);
    end
    if (dq_tag.neg) begin
      val = sat ? {1'b1, {(W-1){1'b0}}} : qn_neg[W-1:0];
    end else begin
      val = sat ? {1'b0, {(W-1){1'b1}}} : dq[W-1:0];
    end
  end

  logic                vld_s8;
  logic                hit_s8;
  logic signed [W-1:0] hitt_s8;
  logic signed [W-1:0] nt_s8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s8 <= 1'b0;
    end else if (en) begin
      vld_s8 <= dq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_s8  <= dq_tag.hit;
      hitt_s8 <= dq_tag.hit ? $signed(val) : dq_tag.nt;
      nt_s8   <= dq_tag.nt;
    end
  end

  logic [W:0] ob_data;

  rsi_obuf #(.DW(W + 1)) u_obuf (
    .clk(clk), .rst(rst),
    .push(en && vld_s8), .push_data({hit_s8, hitt_s8}), .full(full),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(ob_data)
  );

  assign hit   = ob_data[W];
  assign hit_t = $signed(ob_data[W-1:0]);

  // a reported hit never lies beyond the incoming nearest distance
  a_hit_not_farther: assert property (@(posedge clk) disable iff (rst)
    (vld_s8 && hit_s8) |-> (hitt_s8 <= nt_s8))
    else $error("hit distance beyond nearest_t");

  // a forward hit has a quotient that fits before saturation
  a_pos_hit_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (dq_vld && dq_tag.hit && !dq_tag.neg) |-> !dq_tag.ovf)
    else $error("positive hit overflowed the quotient");

  // zero direction can never produce a hit
  a_zero_dir_miss: assert property (@(posedge clk) disable iff (rst)
    (vld_s7 && dv_s7 == '0) |-> !dv_tag_s7.hit)
    else $error("hit with zero direction");

  // a full buffer stays full until the consumer takes a transfer
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !out_ready) |=> full)
    else $error("output buffer lost an entry");

endmodule

`default_nettype wire
